// File: hdl/rmts_pkg.sv
// ----------------------------------------------------------------------------
// rmts_pkg - shared types and constants of the rate monotonic tick scheduler
// Slot count, register map, owner codes and the run record format.
// ----------------------------------------------------------------------------
package rmts_pkg;

  localparam int SLOTS         = 4;
  localparam int MAX_TASKS_DEF = 4;
  localparam int WORD_W        = 16;
  localparam int LEN_W         = 24;
  localparam int OWNER_W       = 3;
  localparam int CFG_IDX_W     = 3;

  // register map
  localparam logic [CFG_IDX_W-1:0] REG_BUDGET_0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD_0 = 3'd4;

  // owner codes: 0..3 are slots
  localparam logic [OWNER_W-1:0] IDLE_OWNER = 3'd4;

  localparam logic [LEN_W-1:0] LEN_MAX = 24'hFFFFFF;

  // output queue
  localparam int OUTQ_DEPTH = 4;
  localparam int OUTQ_PTR_W = 2;
  localparam int OUTQ_CNT_W = 3;

  typedef logic [WORD_W-1:0] word_t;

  typedef struct packed {
    logic [1:0]       slot;
    logic             idle;
    logic [LEN_W-1:0] length;
    logic             last_rec;
  } record_t;

  typedef struct packed {
    logic wr0;
    logic wr1;
  } push_t;

endpackage

// File: hdl/rmts_core.sv
// ----------------------------------------------------------------------------
// rmts_core - per-tick scheduling step
// Holds budgets, phases and the open run; produces up to two run records.
// ----------------------------------------------------------------------------
module rmts_core #(
  parameter int MAX_TASKS = rmts_pkg::MAX_TASKS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic              last_tick,
  input  rmts_pkg::word_t   budget [rmts_pkg::SLOTS],
  input  rmts_pkg::word_t   period [rmts_pkg::SLOTS],
  output rmts_pkg::record_t rec0,
  output rmts_pkg::record_t rec1,
  output rmts_pkg::push_t   push
);

  rmts_pkg::word_t rem_r   [MAX_TASKS];
  rmts_pkg::word_t rem_nxt [MAX_TASKS];
  rmts_pkg::word_t rem_adv [MAX_TASKS];
  rmts_pkg::word_t phase_r   [MAX_TASKS];
  rmts_pkg::word_t phase_nxt [MAX_TASKS];
  logic [rmts_pkg::WORD_W:0] ph_inc [MAX_TASKS];

  logic [rmts_pkg::OWNER_W-1:0] owner_r, owner_nxt, owner;
  logic [rmts_pkg::LEN_W-1:0]   count_r, count_nxt;

  logic            fresh;
  logic            found;
  logic [1:0]      best;
  rmts_pkg::word_t best_per;
  logic            chg;
  rmts_pkg::record_t rec_chg, rec_flush;

  assign fresh = (count_r == '0);

  // advance phases and reload budgets at period boundaries
  always_comb begin
    for (int i = 0; i < MAX_TASKS; i++) begin
      ph_inc[i] = {1'b0, phase_r[i]} + 17'd1;
      if (fresh) begin
        rem_adv[i]   = budget[i];
        phase_nxt[i] = '0;
      end else if (period[i] == '0) begin
        rem_adv[i]   = rem_r[i];
        phase_nxt[i] = '0;
      end else if (ph_inc[i] >= {1'b0, period[i]}) begin
        rem_adv[i]   = budget[i];
        phase_nxt[i] = '0;
      end else begin
        rem_adv[i]   = rem_r[i];
        phase_nxt[i] = ph_inc[i][rmts_pkg::WORD_W-1:0];
      end
    end
  end

  // shortest period with budget left wins, lower slot on a tie
  always_comb begin
    found    = 1'b0;
    best     = '0;
    best_per = '0;
    for (int i = 0; i < MAX_TASKS; i++) begin
      if (period[i] != '0 && rem_adv[i] != '0 && (!found || period[i] < best_per)) begin
        found    = 1'b1;
        best     = 2'(i);
        best_per = period[i];
      end
    end
    owner = found ? {1'b0, best} : rmts_pkg::IDLE_OWNER;
    for (int i = 0; i < MAX_TASKS; i++) begin
      if (found && best == 2'(i)) begin
        rem_nxt[i] = rem_adv[i] - 16'd1;
      end else begin
        rem_nxt[i] = rem_adv[i];
      end
    end
  end

  // run merging and record build
  always_comb begin
    chg       = 1'b0;
    owner_nxt = owner;
    count_nxt = 24'd1;
    if (!fresh) begin
      if (owner_r == owner) begin
        count_nxt = (count_r < rmts_pkg::LEN_MAX) ? count_r + 24'd1 : count_r;
      end else begin
        chg = 1'b1;
      end
    end

    rec_chg.slot     = (owner_r == rmts_pkg::IDLE_OWNER) ? 2'd0 : owner_r[1:0];
    rec_chg.idle     = (owner_r == rmts_pkg::IDLE_OWNER);
    rec_chg.length   = count_r;
    rec_chg.last_rec = !last_tick;

    rec_flush.slot     = (owner_nxt == rmts_pkg::IDLE_OWNER) ? 2'd0 : owner_nxt[1:0];
    rec_flush.idle     = (owner_nxt == rmts_pkg::IDLE_OWNER);
    rec_flush.length   = count_nxt;
    rec_flush.last_rec = 1'b1;
  end

  assign rec0     = chg ? rec_chg : rec_flush;
  assign rec1     = rec_flush;
  assign push.wr0 = step && (chg || last_tick);
  assign push.wr1 = step && chg && last_tick;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      owner_r <= '0;
      count_r <= '0;
      for (int i = 0; i < MAX_TASKS; i++) begin
        rem_r[i]   <= '0;
        phase_r[i] <= '0;
      end
    end else if (step) begin
      for (int i = 0; i < MAX_TASKS; i++) begin
        rem_r[i]   <= rem_nxt[i];
        phase_r[i] <= phase_nxt[i];
      end
      // the tick after a flush reloads everything, so clearing the run is enough
      if (last_tick) begin
        owner_r <= '0;
        count_r <= '0;
      end else begin
        owner_r <= owner_nxt;
        count_r <= count_nxt;
      end
    end
  end

endmodule

// File: hdl/rmts_outq.sv
// ----------------------------------------------------------------------------
// rmts_outq - run record queue
// Small register queue taking up to two records a cycle, giving one.
// ----------------------------------------------------------------------------
module rmts_outq (
  input  logic              clk,
  input  logic              rst_n,
  input  rmts_pkg::record_t rec0,
  input  rmts_pkg::record_t rec1,
  input  rmts_pkg::push_t   push,
  output logic              room,
  output logic              head_valid,
  input  logic              head_ready,
  output rmts_pkg::record_t head
);

  rmts_pkg::record_t mem [rmts_pkg::OUTQ_DEPTH];

  logic [rmts_pkg::OUTQ_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [rmts_pkg::OUTQ_CNT_W-1:0] count_r, count_nxt;
  logic pop;

  assign pop        = head_valid && head_ready;
  assign head_valid = (count_r != '0);
  assign head       = mem[rd_ptr_r];
  // room for a two-record tick
  assign room       = (count_r <= 3'(rmts_pkg::OUTQ_DEPTH - 2));

  assign wr_ptr_nxt = wr_ptr_r + {1'b0, push.wr0} + {1'b0, push.wr1};
  assign rd_ptr_nxt = rd_ptr_r + {1'b0, pop};
  assign count_nxt  = count_r + {2'b0, push.wr0} + {2'b0, push.wr1} - {2'b0, pop};

  always_ff @(posedge clk) begin
    if (push.wr0) begin
      mem[wr_ptr_r] <= rec0;
    end
    if (push.wr1) begin
      mem[wr_ptr_r + 2'd1] <= rec1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// File: hdl/rate_monotonic_tick_scheduler.sv
// ----------------------------------------------------------------------------
// rate_monotonic_tick_scheduler - fixed-priority tick scheduler
// Steps four rate monotonic task slots one tick per input transfer and
// reports merged runs of ticks as (slot or idle, length) records.
// ----------------------------------------------------------------------------
// Usage:
//   cfg_*  : one write transfer per register; index 0..3 budget of slots
//            0..3, index 4..7 their periods. A period of zero disables a slot.
//            Write only while the block is idle. cfg_ready is always high.
//   in_*   : one transfer is one scheduling tick; in_last_tick ends the
//            hyperperiod, flushing the open run and restarting the schedule.
//   out_*  : run records; a tick yields zero, one or two of them, the final
//            one of a tick carrying out_final_of_tick.
//   Queueing: a tick's records are registered in the queue on its transfer.
//   Throughput: one tick per cycle unless stalled; the queue absorbs the
//            odd two-record tick; in_ready depends only on its fill level.
//   Reset: budgets, periods, run state and queue clear; no run is open.
//   Stall: while out_ready is low the queue holds its records and in_ready
//            drops once fewer than two free entries remain.
// ----------------------------------------------------------------------------
module rate_monotonic_tick_scheduler #(
  parameter int MAX_TASKS = rmts_pkg::MAX_TASKS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // tick input
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             in_last_tick,
  // run records
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [1:0]                       out_run_task,
  output logic                             out_run_idle,
  output logic [rmts_pkg::LEN_W-1:0]       out_run_length,
  output logic                             out_final_of_tick,
  // configuration writes
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [rmts_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rmts_pkg::WORD_W-1:0]      cfg_data
);

  rmts_pkg::word_t   budget_r [rmts_pkg::SLOTS];
  rmts_pkg::word_t   period_r [rmts_pkg::SLOTS];
  rmts_pkg::record_t rec0, rec1, head;
  rmts_pkg::push_t   push;
  logic              room;
  logic              step;
  logic              cfg_wr;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign in_ready  = room;
  assign step      = in_valid && in_ready;

  // register file: every index in the 3-bit space maps to a register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < rmts_pkg::SLOTS; i++) begin
        budget_r[i] <= '0;
        period_r[i] <= '0;
      end
    end else if (cfg_wr) begin
      if (cfg_index < rmts_pkg::REG_PERIOD_0) begin
        budget_r[cfg_index[1:0]] <= cfg_data;
      end else begin
        period_r[cfg_index[1:0]] <= cfg_data;
      end
    end
  end

  // scheduling step: budgets, phases, open run
  rmts_core #(
    .MAX_TASKS(MAX_TASKS)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .last_tick (in_last_tick),
    .budget    (budget_r),
    .period    (period_r),
    .rec0      (rec0),
    .rec1      (rec1),
    .push      (push)
  );

  // record queue decouples the tick side from the receiver
  rmts_outq u_outq (
    .clk        (clk),
    .rst_n      (rst_n),
    .rec0       (rec0),
    .rec1       (rec1),
    .push       (push),
    .room       (room),
    .head_valid (out_valid),
    .head_ready (out_ready),
    .head       (head)
  );

  assign out_run_task      = head.slot;
  assign out_run_idle      = head.idle;
  assign out_run_length    = head.length;
  assign out_final_of_tick = head.last_rec;

endmodule

// File: tb/sv/rmts_checker.sv
// ----------------------------------------------------------------------------
// rmts_checker - run record predictor and scoreboard
// Follows configuration writes and tick transfers, works out the run records
// each tick must produce and compares every record transfer against them.
// ----------------------------------------------------------------------------
module rmts_checker #(
  parameter int MAX_TASKS = rmts_pkg::MAX_TASKS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  logic                           in_last_tick,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  logic [1:0]                     out_run_task,
  input  logic                           out_run_idle,
  input  logic [rmts_pkg::LEN_W-1:0]     out_run_length,
  input  logic                           out_final_of_tick,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [rmts_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rmts_pkg::WORD_W-1:0]    cfg_data,
  output int                             fail_count,
  output int                             runs_pending
);

  rmts_pkg::word_t              slot_budget [rmts_pkg::SLOTS];
  rmts_pkg::word_t              slot_period [rmts_pkg::SLOTS];
  rmts_pkg::word_t              budget_left [rmts_pkg::SLOTS];
  rmts_pkg::word_t              slot_phase  [rmts_pkg::SLOTS];
  logic [rmts_pkg::OWNER_W-1:0] open_owner;
  logic [rmts_pkg::LEN_W-1:0]   open_len;
  rmts_pkg::record_t            runs_due [$];
  int                           mismatches = 0;
  int                           due_count  = 0;

  assign fail_count   = mismatches;
  assign runs_pending = due_count;

  function automatic rmts_pkg::record_t make_run(logic [rmts_pkg::OWNER_W-1:0] owner,
                                                 logic [rmts_pkg::LEN_W-1:0] len,
                                                 logic fin);
    rmts_pkg::record_t r;
    r.idle     = (owner == rmts_pkg::IDLE_OWNER);
    r.slot     = r.idle ? 2'd0 : owner[1:0];
    r.length   = len;
    r.last_rec = fin;
    return r;
  endfunction

  // append one expected record at the tail
  task automatic add_run(input rmts_pkg::record_t r);
    runs_due = {runs_due, r};
  endtask

  task automatic restart_schedule();
    for (int i = 0; i < rmts_pkg::SLOTS; i++) begin
      budget_left[i] = slot_budget[i];
      slot_phase[i]  = '0;
    end
    open_owner = '0;
    open_len   = '0;
  endtask

  // advance one tick and queue the records it closes
  task automatic schedule_tick(input logic last);
    int                           best;
    logic [rmts_pkg::OWNER_W-1:0] owner;
    logic [rmts_pkg::WORD_W:0]    nxt;
    best = -1;
    if (open_len == 0) begin
      for (int i = 0; i < rmts_pkg::SLOTS; i++) begin
        budget_left[i] = slot_budget[i];
        slot_phase[i]  = '0;
      end
    end else begin
      for (int i = 0; i < MAX_TASKS && i < rmts_pkg::SLOTS; i++) begin
        if (slot_period[i] == 0) begin
          slot_phase[i] = '0;
        end else begin
          nxt = {1'b0, slot_phase[i]} + 1'b1;
          if (nxt >= {1'b0, slot_period[i]}) begin
            slot_phase[i]  = '0;
            budget_left[i] = slot_budget[i];
          end else begin
            slot_phase[i] = nxt[rmts_pkg::WORD_W-1:0];
          end
        end
      end
    end
    for (int i = 0; i < MAX_TASKS && i < rmts_pkg::SLOTS; i++) begin
      if (slot_period[i] != 0 && budget_left[i] != 0 &&
          (best < 0 || slot_period[i] < slot_period[best]))
        best = i;
    end
    if (best >= 0) begin
      budget_left[best] = budget_left[best] - 1'b1;
      owner = best[rmts_pkg::OWNER_W-1:0];
    end else begin
      owner = rmts_pkg::IDLE_OWNER;
    end
    if (open_len == 0) begin
      open_owner = owner;
      open_len   = 1;
    end else if (open_owner == owner) begin
      if (open_len != rmts_pkg::LEN_MAX)
        open_len = open_len + 1'b1;
    end else begin
      add_run(make_run(open_owner, open_len, !last));
      open_owner = owner;
      open_len   = 1;
    end
    if (last) begin
      add_run(make_run(open_owner, open_len, 1'b1));
      restart_schedule();
    end
  endtask

  task automatic note_mismatch(input string what);
    mismatches++;
    if (mismatches <= 10)
      $display("[%0t] run record mismatch: %s", $realtime, what);
  endtask

  task automatic check_run();
    rmts_pkg::record_t want;
    if (runs_due.size() == 0) begin
      note_mismatch($sformatf("unexpected record task %0d idle %0b len %0d final %0b",
                              out_run_task, out_run_idle, out_run_length,
                              out_final_of_tick));
    end else begin
      want = runs_due.pop_front();
      if (out_run_task !== want.slot || out_run_idle !== want.idle ||
          out_run_length !== want.length || out_final_of_tick !== want.last_rec)
        note_mismatch($sformatf({"expected task %0d idle %0b len %0d final %0b,",
                                 " got task %0d idle %0b len %0d final %0b"},
                                want.slot, want.idle, want.length, want.last_rec,
                                out_run_task, out_run_idle, out_run_length,
                                out_final_of_tick));
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < rmts_pkg::SLOTS; i++) begin
        slot_budget[i] = '0;
        slot_period[i] = '0;
      end
      restart_schedule();
      runs_due.delete();
    end else begin
      if (out_valid && out_ready)
        check_run();
      // a tick at this edge still sees the registers from before the write
      if (in_valid && in_ready)
        schedule_tick(in_last_tick);
      if (cfg_valid && cfg_ready) begin
        if (cfg_index < rmts_pkg::REG_PERIOD_0)
          slot_budget[cfg_index[1:0]] = cfg_data;
        else
          slot_period[cfg_index[1:0]] = cfg_data;
      end
    end
    due_count = runs_due.size();
  end

endmodule

// File: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb - stimulus and verdict for the rate monotonic tick scheduler
// Programs budgets and periods between phases, feeds ticks with random gaps
// and a randomly stalling record sink, and leaves all checking to the
// scoreboard beside the block.
// ----------------------------------------------------------------------------
module tb;

  localparam int MAX_TASKS     = rmts_pkg::MAX_TASKS_DEF;
  localparam int TICK_TARGET   = 1350;
  localparam int HOLD_CYCLES   = 160;   // long sink hold-off under pressure
  localparam int SETTLE_CYCLES = 6;     // records are registered in the queue after a tick
  localparam int QUIET_LIMIT   = 3000;  // cycles without any transfer

  logic                           clk          = 1'b0;
  logic                           rst_n        = 1'b0;
  logic                           in_valid     = 1'b0;
  logic                           in_ready;
  logic                           in_last_tick = 1'b0;
  logic                           out_valid;
  logic                           out_ready    = 1'b0;
  logic [1:0]                     out_run_task;
  logic                           out_run_idle;
  logic [rmts_pkg::LEN_W-1:0]     out_run_length;
  logic                           out_final_of_tick;
  logic                           cfg_valid    = 1'b0;
  logic                           cfg_ready;
  logic [rmts_pkg::CFG_IDX_W-1:0] cfg_index    = '0;
  logic [rmts_pkg::WORD_W-1:0]    cfg_data     = '0;
  int                             fail_count;
  int                             runs_pending;

  // knobs shared between the tick source and the record sink
  int              tx_gap_max   = 12;
  int              rx_stall_max = 12;
  bit              squeeze      = 1'b0;
  int              ticks_sent   = 0;
  int              quiet_cycles = 0;
  rmts_pkg::word_t plan_budget [rmts_pkg::SLOTS];
  rmts_pkg::word_t plan_period [rmts_pkg::SLOTS];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  rate_monotonic_tick_scheduler #(
    .MAX_TASKS(MAX_TASKS)
  ) u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_last_tick     (in_last_tick),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_run_task     (out_run_task),
    .out_run_idle     (out_run_idle),
    .out_run_length   (out_run_length),
    .out_final_of_tick(out_final_of_tick),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  rmts_checker #(
    .MAX_TASKS(MAX_TASKS)
  ) u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_last_tick     (in_last_tick),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_run_task     (out_run_task),
    .out_run_idle     (out_run_idle),
    .out_run_length   (out_run_length),
    .out_final_of_tick(out_final_of_tick),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .fail_count       (fail_count),
    .runs_pending     (runs_pending)
  );

  // Watchdog: any transfer on any channel clears the count; a run that
  // stalls for longer than the slowest legal stretch is declared dead.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Hold valid across back-to-back writes; the caller drops it at the end.
  task automatic cfg_write(input logic [rmts_pkg::CFG_IDX_W-1:0] idx,
                           input rmts_pkg::word_t value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // Write all eight registers from the plan, budgets first.
  task automatic load_config();
    for (int i = 0; i < rmts_pkg::SLOTS; i++)
      cfg_write(rmts_pkg::REG_BUDGET_0 + i[rmts_pkg::CFG_IDX_W-1:0], plan_budget[i]);
    for (int i = 0; i < rmts_pkg::SLOTS; i++)
      cfg_write(rmts_pkg::REG_PERIOD_0 + i[rmts_pkg::CFG_IDX_W-1:0], plan_period[i]);
    cfg_valid <= 1'b0;
  endtask

  // Offer one tick. Valid is only dropped when a gap is drawn, so a
  // zero gap keeps it high straight into the next transfer.
  task automatic send_tick(input logic last);
    int gap;
    gap = $urandom_range(0, tx_gap_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_last_tick <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    ticks_sent++;
  endtask

  // Random ticks; a hyperperiod end now and then, optionally forced at the
  // end; phases that do not force it leave a run open across the next write.
  task automatic run_ticks(input int count, input bit close_at_end);
    for (int k = 0; k < count; k++)
      send_tick(($urandom_range(0, 11) == 0) || (close_at_end && k == count - 1));
  endtask

  // Drop valid, let every predicted record drain, then wait SETTLE_CYCLES
  // so that a tick that produced no record has fully retired.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (runs_pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Mostly short periods so owners change often; some disabled slots,
  // the odd full-scale value, and budgets that are usually small.
  task automatic pick_config();
    int sel;
    for (int i = 0; i < rmts_pkg::SLOTS; i++) begin
      sel = $urandom_range(0, 19);
      if (sel < 4)
        plan_period[i] = '0;
      else if (sel == 4)
        plan_period[i] = '1;
      else if (sel < 9)
        plan_period[i] = rmts_pkg::word_t'($urandom_range(1, 40));
      else
        plan_period[i] = rmts_pkg::word_t'($urandom_range(1, 10));
      sel = $urandom_range(0, 19);
      if (sel < 2)
        plan_budget[i] = '0;
      else if (sel == 2)
        plan_budget[i] = '1;
      else if (sel == 3)
        plan_budget[i] = rmts_pkg::word_t'($urandom());
      else
        plan_budget[i] = rmts_pkg::word_t'($urandom_range(1, 4));
    end
  endtask

  // Record sink: draw a stall per record, and once, on request, hold off
  // for a long stretch so the output queue fills and input backs up.
  initial begin : record_sink
    int stall;
    bit squeezed;
    squeezed = 1'b0;
    forever begin
      if (squeeze && !squeezed) begin
        squeezed = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      stall = $urandom_range(0, rx_stall_max);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  initial begin : tick_source
    int phase_no;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // All slots disabled at full-scale budgets: pure idle time, then a
    // hyperperiod that ends on its very first tick.
    plan_budget = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};
    plan_period = '{16'd0, 16'd0, 16'd0, 16'd0};
    load_config();
    send_tick(1'b0);
    send_tick(1'b0);
    send_tick(1'b1);
    send_tick(1'b1);
    settle();

    // Slots 0 and 1 tie on period, slot 2 is enabled with no budget and
    // slot 3 sits at the longest period. Leave the run open at the end.
    plan_budget = '{16'd1, 16'd2, 16'd0, 16'hFFFF};
    plan_period = '{16'd3, 16'd3, 16'd5, 16'hFFFF};
    load_config();
    repeat (6) send_tick(1'b0);
    settle();

    // Shorten the periods under the open run so advanced phases overshoot
    // and wrap; period 1 reloads slot 3 on every tick.
    plan_period = '{16'd2, 16'd2, 16'd5, 16'd1};
    load_config();
    repeat (7) send_tick(1'b0);
    send_tick(1'b1);
    send_tick(1'b1);
    settle();

    // Random phases until the tick budget is spent.
    phase_no = 0;
    while (ticks_sent < TICK_TARGET) begin
      tx_gap_max   = ($urandom_range(0, 3) == 0) ? 0 : 12;
      rx_stall_max = ($urandom_range(0, 3) == 0) ? 0 : 12;
      if (phase_no == 2) begin
        // Interleave slots 0 and 1 with idle ticks so nearly every tick closes a
        // run, and starve the sink while ticks keep coming back to back.
        plan_budget = '{16'd1, 16'd1, 16'd0, 16'd0};
        plan_period = '{16'd2, 16'd3, 16'd0, 16'd0};
        load_config();
        tx_gap_max = 0;
        squeeze    = 1'b1;
        run_ticks(60, 1'b1);
        settle();
        squeeze = 1'b0;
      end else begin
        pick_config();
        load_config();
        run_ticks($urandom_range(8, 50), $urandom_range(0, 1));
        settle();
      end
      phase_no++;
    end

    if (fail_count == 0 && runs_pending == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
